[src/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
// Assertions are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, ck, rn, prop, msg)
`define ASSERT_NEVER(lbl, ck, rn, cond, msg)
`endif
`endif

[src/cpd_pkg.sv]
// Shared types and constants of the canonical prefix-code decoder.
// No dependencies.
package cpd_pkg;

  localparam int FAST_WIDTH  = 8;
  localparam int FAST_DEPTH  = 256;
  localparam int ALPHA_DEPTH = 256;
  localparam int LEN_W       = 24;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_COUNTS = 2'd1;
  localparam logic [1:0] PH_ALPHA  = 2'd2;
  localparam logic [1:0] PH_DECODE = 2'd3;

  localparam logic [1:0] ST_SYMBOL  = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_BAD_CODE = 2'd2;
  localparam logic [1:0] ST_EARLY   = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [7:0] sym;
    logic [1:0] status;
    logic       last;
  } res_t;

endpackage

[src/cpd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/cpd_ctrl.sv]
// Header parser, table builder and decode sequencer around three RAMs.
// Depends on cpd_pkg, cpd_ram and assert_macros.svh.
`include "assert_macros.svh"
module cpd_ctrl #(
  parameter int ALPHABET_SIZE  = 256,
  parameter int MAX_CODE_WIDTH = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          in_last_in,
  input  logic [cpd_pkg::LEN_W-1:0]     out_len,
  input  logic                          out_free,
  output cpd_pkg::res_t                 res
);
  import cpd_pkg::*;

  localparam int LW_AW = $clog2(MAX_CODE_WIDTH);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_BLD_NEXT = 4'd1;
  localparam logic [3:0] S_BLD_FILL = 4'd2;
  localparam logic [3:0] S_BLD_CLR  = 4'd3;
  localparam logic [3:0] S_CHECK    = 4'd4;
  localparam logic [3:0] S_FAST     = 4'd5;
  localparam logic [3:0] S_LONG     = 4'd6;
  localparam logic [3:0] S_SYM      = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;
  localparam logic [3:0] S_HALT     = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [3:0]       wt_r, wt_nxt;
  logic [8:0]       hdr_r, hdr_nxt;
  logic [11:0]      alen_r, alen_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic             final_r, final_nxt;
  logic [23:0]      buf_r, buf_nxt;
  logic [4:0]       bh_r, bh_nxt;
  logic [LEN_W-1:0] emitted_r, emitted_nxt;
  logic [3:0]       nres_r, nres_nxt;
  logic [3:0]       bw_r, bw_nxt;
  logic [7:0]       bk_r, bk_nxt;
  logic [8:0]       fill_r, fill_nxt;
  logic [7:0]       span_r, span_nxt;
  logic [8:0]       sidx_r, sidx_nxt;
  logic [3:0]       lw_r, lw_nxt;
  logic [7:0]       rsym_r, rsym_nxt;
  logic [1:0]       rst_r, rst_nxt;
  logic [7:0]       cnt_r [MAX_CODE_WIDTH];
  logic             cnt_we;

  // RAM ports
  logic             a_we, a_re, f_we, f_re, l_we, l_re;
  logic [7:0]       a_waddr, a_raddr, a_rdata, f_waddr, f_raddr;
  logic [11:0]      f_wdata, f_rdata;
  logic [LW_AW-1:0] l_waddr, l_raddr;
  logic [32:0]      l_wdata, l_rdata;

  cpd_ram #(.WIDTH(8), .DEPTH(ALPHA_DEPTH)) u_alpha (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(in_byte),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );
  cpd_ram #(.WIDTH(12), .DEPTH(FAST_DEPTH)) u_fast (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
  );
  cpd_ram #(.WIDTH(33), .DEPTH(MAX_CODE_WIDTH)) u_lim (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
  );

  // header arithmetic
  logic [15:0] sum_dbl, sum_sat;
  logic [16:0] sum_add, hdr_off;
  logic [11:0] alen_add;
  logic [3:0]  top_w;
  logic        hdr_bad;
  // decode arithmetic
  logic [31:0] peek_wide;
  logic [3:0]  fw, tw;
  logic [4:0]  bh_take;
  logic [23:0] buf_take, code_wide;
  logic [15:0] code16, mask16;
  logic [17:0] idx;
  logic        hit, idx_bad;
  logic        sym_last;
  logic [LEN_W-1:0] emitted_inc;

  always_comb begin
    sum_dbl  = (sum_r > 16'h7FFF) ? 16'hFFFF : {sum_r[14:0], 1'b0};
    hdr_off  = {5'd0, alen_r} - {1'b0, sum_dbl};
    sum_add  = {1'b0, sum_dbl} + {9'd0, in_byte};
    sum_sat  = sum_add[16] ? 16'hFFFF : sum_add[15:0];
    alen_add = alen_r + {4'd0, in_byte};
    top_w    = (wt_r < 4'(FAST_WIDTH)) ? wt_r : 4'(FAST_WIDTH);
    hdr_bad  = in_byte[7] || (in_byte[6:0] > 7'd15)
               || (in_byte[6:0] > 7'(MAX_CODE_WIDTH));

    peek_wide = {buf_r, 8'h00} >> bh_r;
    fw        = f_rdata[11:8];
    tw        = (state_r == S_FAST) ? fw : lw_r;
    bh_take   = bh_r - {1'b0, tw};
    buf_take  = buf_r & ((24'd1 << bh_take) - 24'd1);
    code_wide = buf_r >> (bh_r - {1'b0, lw_r});
    mask16    = (16'd1 << lw_r) - 16'd1;
    code16    = code_wide[15:0] & mask16;
    hit       = (lw_r <= wt_r) && (code16 < l_rdata[15:0]);
    idx       = {3'd0, code16[14:0]} + {l_rdata[32], l_rdata[32:16]};
    idx_bad   = idx[17] || (idx[16:0] >= {5'd0, alen_r});
    emitted_inc = emitted_r + 1'b1;
    sym_last  = (emitted_inc >= out_len);
  end

  always_comb begin
    state_nxt = state_r;  phase_nxt = phase_r;  wt_nxt = wt_r;
    hdr_nxt = hdr_r;  alen_nxt = alen_r;  sum_nxt = sum_r;
    final_nxt = final_r;  buf_nxt = buf_r;  bh_nxt = bh_r;
    emitted_nxt = emitted_r;  nres_nxt = nres_r;
    bw_nxt = bw_r;  bk_nxt = bk_r;  fill_nxt = fill_r;  span_nxt = span_r;
    sidx_nxt = sidx_r;  lw_nxt = lw_r;  rsym_nxt = rsym_r;  rst_nxt = rst_r;
    cnt_we = 1'b0;
    a_we = 1'b0;  a_waddr = hdr_r[7:0];  a_re = 1'b0;  a_raddr = sidx_r[7:0];
    f_we = 1'b0;  f_waddr = fill_r[7:0];  f_wdata = '0;
    f_re = 1'b0;  f_raddr = peek_wide[7:0];
    l_we = 1'b0;  l_waddr = hdr_r[LW_AW-1:0];  l_wdata = {hdr_off, sum_sat};
    l_re = 1'b0;  l_raddr = LW_AW'(lw_r - 4'd1);
    res = '0;
    in_ready = (state_r == S_IDLE) || (state_r == S_HALT);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          final_nxt = in_last_in;
          unique case (phase_r)
            PH_FIRST: begin
              if (hdr_bad) begin
                rsym_nxt = 8'd0;  rst_nxt = ST_BAD_HDR;  state_nxt = S_EMIT;
              end else begin
                wt_nxt = in_byte[3:0];
                hdr_nxt = '0;  alen_nxt = '0;  sum_nxt = '0;
                phase_nxt = PH_COUNTS;
                if (in_byte[3:0] == 4'd0) begin
                  fill_nxt = '0;  bw_nxt = '0;  bk_nxt = '0;  sidx_nxt = '0;
                  state_nxt = S_BLD_NEXT;
                end else if (in_last_in) begin
                  rsym_nxt = 8'd0;  rst_nxt = ST_EARLY;  state_nxt = S_EMIT;
                end
              end
            end
            PH_COUNTS: begin
              l_we = 1'b1;
              cnt_we = 1'b1;
              sum_nxt = sum_sat;
              alen_nxt = alen_add;
              hdr_nxt = hdr_r + 9'd1;
              if (hdr_r + 9'd1 >= {5'd0, wt_r}) begin
                if (alen_add > 12'(ALPHABET_SIZE)) begin
                  rsym_nxt = 8'd0;  rst_nxt = ST_BAD_HDR;  state_nxt = S_EMIT;
                end else begin
                  hdr_nxt = '0;
                  phase_nxt = PH_ALPHA;
                  if (alen_add == 12'd0) begin
                    fill_nxt = '0;  bw_nxt = '0;  bk_nxt = '0;  sidx_nxt = '0;
                    state_nxt = S_BLD_NEXT;
                  end else if (in_last_in) begin
                    rsym_nxt = 8'd0;  rst_nxt = ST_EARLY;  state_nxt = S_EMIT;
                  end
                end
              end else if (in_last_in) begin
                rsym_nxt = 8'd0;  rst_nxt = ST_EARLY;  state_nxt = S_EMIT;
              end
            end
            PH_ALPHA: begin
              a_we = 1'b1;
              hdr_nxt = hdr_r + 9'd1;
              if ({3'd0, hdr_r + 9'd1} >= alen_r) begin
                fill_nxt = '0;  bw_nxt = '0;  bk_nxt = '0;  sidx_nxt = '0;
                state_nxt = S_BLD_NEXT;
              end else if (in_last_in) begin
                rsym_nxt = 8'd0;  rst_nxt = ST_EARLY;  state_nxt = S_EMIT;
              end
            end
            default: begin
              buf_nxt = {buf_r[15:0], in_byte};
              bh_nxt = bh_r + 5'd8;
              nres_nxt = '0;
              state_nxt = S_CHECK;
            end
          endcase
        end
      end
      S_BLD_NEXT: begin
        if (fill_r[8]) begin
          phase_nxt = PH_DECODE;  nres_nxt = '0;  state_nxt = S_CHECK;
        end else if (bw_r != 4'd0 && bk_r != 8'd0) begin
          // fetch the next symbol, then repeat it over its span
          a_re = 1'b1;
          span_nxt = 8'h80 >> (bw_r - 4'd1);
          state_nxt = S_BLD_FILL;
        end else if (bw_r >= top_w) begin
          state_nxt = S_BLD_CLR;
        end else begin
          bw_nxt = bw_r + 4'd1;
          bk_nxt = cnt_r[bw_r[LW_AW-1:0]];
        end
      end
      S_BLD_FILL: begin
        f_we = 1'b1;
        f_wdata = {bw_r, a_rdata};
        fill_nxt = fill_r + 9'd1;
        span_nxt = span_r - 8'd1;
        if (span_r == 8'd1 || fill_r == 9'd255) begin
          bk_nxt = bk_r - 8'd1;
          sidx_nxt = sidx_r + 9'd1;
          state_nxt = S_BLD_NEXT;
        end
      end
      S_BLD_CLR: begin
        if (fill_r[8]) begin
          phase_nxt = PH_DECODE;  nres_nxt = '0;  state_nxt = S_CHECK;
        end else begin
          f_we = 1'b1;
          fill_nxt = fill_r + 9'd1;
        end
      end
      S_CHECK: begin
        if (nres_r == 4'd8) begin
          state_nxt = S_IDLE;
        end else if (emitted_r >= out_len) begin
          state_nxt = S_HALT;
        end else begin
          f_re = 1'b1;
          state_nxt = S_FAST;
        end
      end
      S_FAST: begin
        if (fw != 4'd0) begin
          if ({1'b0, fw} > bh_r) begin
            if (final_r) begin
              rsym_nxt = 8'd0;  rst_nxt = ST_EARLY;  state_nxt = S_EMIT;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            bh_nxt = bh_take;  buf_nxt = buf_take;
            rsym_nxt = f_rdata[7:0];  rst_nxt = ST_SYMBOL;  state_nxt = S_EMIT;
          end
        end else if (MAX_CODE_WIDTH <= FAST_WIDTH) begin
          // no widths beyond the table: a long code cannot match
          rsym_nxt = 8'd0;  rst_nxt = ST_BAD_CODE;  state_nxt = S_EMIT;
        end else begin
          lw_nxt = 4'(FAST_WIDTH + 1);
          l_re = 1'b1;
          l_raddr = LW_AW'(FAST_WIDTH);
          state_nxt = S_LONG;
        end
      end
      S_LONG: begin
        if ({1'b0, lw_r} > bh_r) begin
          if (final_r) begin
            rsym_nxt = 8'd0;  rst_nxt = ST_EARLY;  state_nxt = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (hit) begin
          if (idx_bad) begin
            rsym_nxt = 8'd0;  rst_nxt = ST_BAD_CODE;  state_nxt = S_EMIT;
          end else begin
            bh_nxt = bh_take;  buf_nxt = buf_take;
            a_re = 1'b1;
            a_raddr = idx[7:0];
            state_nxt = S_SYM;
          end
        end else if (lw_r == 4'(MAX_CODE_WIDTH)) begin
          rsym_nxt = 8'd0;  rst_nxt = ST_BAD_CODE;  state_nxt = S_EMIT;
        end else begin
          // extend the code by one bit
          lw_nxt = lw_r + 4'd1;
          l_re = 1'b1;
          l_raddr = lw_r[LW_AW-1:0];
        end
      end
      S_SYM: begin
        rsym_nxt = a_rdata;  rst_nxt = ST_SYMBOL;  state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          res.valid = 1'b1;
          res.sym = rsym_r;
          res.status = rst_r;
          res.last = (rst_r == ST_SYMBOL) ? sym_last : 1'b1;
          if (rst_r == ST_SYMBOL) begin
            emitted_nxt = emitted_inc;
          end
          nres_nxt = nres_r + 4'd1;
          state_nxt = res.last ? S_HALT : S_CHECK;
        end
      end
      S_HALT: begin
        state_nxt = S_HALT;
      end
      default: begin
        state_nxt = S_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  phase_r <= PH_FIRST;  wt_r <= '0;
      hdr_r <= '0;  alen_r <= '0;  sum_r <= '0;  final_r <= 1'b0;
      buf_r <= '0;  bh_r <= '0;  emitted_r <= '0;  nres_r <= '0;
      bw_r <= '0;  bk_r <= '0;  fill_r <= '0;  span_r <= '0;
      sidx_r <= '0;  lw_r <= '0;
    end else begin
      state_r <= state_nxt;  phase_r <= phase_nxt;  wt_r <= wt_nxt;
      hdr_r <= hdr_nxt;  alen_r <= alen_nxt;  sum_r <= sum_nxt;
      final_r <= final_nxt;  buf_r <= buf_nxt;  bh_r <= bh_nxt;
      emitted_r <= emitted_nxt;  nres_r <= nres_nxt;
      bw_r <= bw_nxt;  bk_r <= bk_nxt;  fill_r <= fill_nxt;
      span_r <= span_nxt;  sidx_r <= sidx_nxt;  lw_r <= lw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rsym_r <= rsym_nxt;
    rst_r <= rst_nxt;
    if (cnt_we) begin
      cnt_r[hdr_r[LW_AW-1:0]] <= in_byte;
    end
  end

  `ASSERT_PROP(a_bits_bound, clk, rst_n, bh_r <= 5'd22, "bit buffer overrun")
  `ASSERT_PROP(a_res_bound, clk, rst_n, nres_r <= 4'd8, "too many words per input")
  `ASSERT_PROP(a_halt_sticky, clk, rst_n, state_r == S_HALT |=> state_r == S_HALT, "left halt")
  `ASSERT_NEVER(a_lookup_phase, clk, rst_n, state_r == S_CHECK && phase_r != PH_DECODE, "early lookup")

endmodule

[src/canonical_prefix_code_decoder_unit.sv]
// Canonical prefix-code decoder: header bytes are accepted while the controller is
// idle; it then builds the 256-entry lookup table, and each decoded word is found
// through that table, or, for codes longer than 8 bits, by extending the code one
// bit at a time against the limit RAM.
module canonical_prefix_code_decoder_unit #(
  parameter int ALPHABET_SIZE  = 256,
  parameter int MAX_CODE_WIDTH = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_output_length,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_last_out
);
  import cpd_pkg::*;

  logic [LEN_W-1:0] len_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic [1:0]       out_status_r;
  logic             out_last_r;
  logic             out_free;
  res_t             res;

  assign cfg_ready = 1'b1;
  assign out_free = !out_valid_r || out_ready;

  cpd_ctrl #(
    .ALPHABET_SIZE(ALPHABET_SIZE), .MAX_CODE_WIDTH(MAX_CODE_WIDTH)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_byte(in_byte), .in_last_in(in_last_in),
    .out_len(len_r), .out_free(out_free), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_output_length;
      end
      // hold the word until taken
      if (res.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_byte_r <= res.sym;
      out_status_r <= res.status;
      out_last_r <= res.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte = out_byte_r;
  assign out_status = out_status_r;
  assign out_last_out = out_last_r;

endmodule
